// ===== hw/rtl/int64_divide_modulo_defines.svh =====
// assertion macros for the divider checker
`ifndef INT64_DIVIDE_MODULO_DEFINES_SVH
`define INT64_DIVIDE_MODULO_DEFINES_SVH

`define DM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

`define DM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/i64dm_pkg.sv =====
// package for the 64-bit divider: request codes and stage payload types
`timescale 1ns / 1ps
package i64dm_pkg;
  localparam int unsigned DataW = 64;

  typedef enum logic [1:0] {
    REQ_UDIV = 2'd0,
    REQ_UREM = 2'd1,
    REQ_SDIV = 2'd2,
    REQ_SREM = 2'd3
  } req_type_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } dm_req_t;

  typedef struct packed {
    logic [DataW-1:0] answer;
    logic             divide_by_zero;
  } dm_rsp_t;

  // per-item state carried through the iteration stages
  typedef struct packed {
    logic [DataW-1:0] rem;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] den;
    logic [DataW-1:0] orig_n;
    logic             want_rem;
    logic             neg_q;
    logic             neg_r;
    logic             dz;
  } dm_work_t;
endpackage

// ===== hw/rtl/i64dm_if.sv =====
// valid/ready channel interfaces for requests and responses
`timescale 1ns / 1ps
interface i64dm_req_if;
  logic                valid;
  logic                ready;
  i64dm_pkg::dm_req_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface i64dm_rsp_if;
  logic                valid;
  logic                ready;
  i64dm_pkg::dm_rsp_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/int64_divide_modulo.sv =====
// 64-bit unsigned/signed divider and modulo, fully pipelined restoring array
// usage:
//   req channel carries req_type, dividend and divisor; rsp carries answer
//   and divide_by_zero. one transaction per channel per item, in order.
//   the datapath is a chain of register stages: one input stage taking
//   magnitudes, DataW/BitsPerStage restoring stages of BitsPerStage
//   quotient bits each (one 65-bit subtract per bit), and one output stage
//   fixing signs. DataW/BitsPerStage + 2 registers deep. throughput is
//   one transaction per cycle while the receiver keeps up, set by the stage
//   chain, each stage holding its own item.
//   a zero divisor raises divide_by_zero and returns all ones for quotients
//   or the dividend for remainders.
//   reset clears every stage valid bit; payload registers are not reset.
//   when the receiver stalls, a stage advances only if the stage after it is
//   empty or moving, so bubbles are squeezed out and nothing is lost.
`timescale 1ns / 1ps
module int64_divide_modulo #(
  parameter int unsigned BitsPerStage = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  i64dm_req_if.sink   req,
  i64dm_rsp_if.source rsp
);
  import i64dm_pkg::*;

  localparam int unsigned NStage = DataW / BitsPerStage;

  dm_work_t          work_q [NStage+1];
  logic [NStage:0]   vld_q;
  logic [NStage:0]   adv;
  dm_rsp_t           out_q;
  logic              out_vld_q;
  logic              out_adv;

  assign out_adv = !out_vld_q || rsp.ready;
  assign adv[NStage] = !vld_q[NStage] || out_adv;
  for (genvar s = 0; s < NStage; s++) begin : g_adv
    assign adv[s] = !vld_q[s] || adv[s+1];
  end
  assign req.ready = adv[0];

  // input stage: magnitudes and sign bookkeeping
  dm_work_t w0_d;
  logic     sgn, nn, dn;
  always_comb begin
    sgn = req.payload.req_type[1];
    nn  = sgn & req.payload.dividend[DataW-1];
    dn  = sgn & req.payload.divisor[DataW-1];
    w0_d.rem      = '0;
    w0_d.quo      = nn ? (DataW'(0) - req.payload.dividend) : req.payload.dividend;
    w0_d.den      = dn ? (DataW'(0) - req.payload.divisor) : req.payload.divisor;
    w0_d.orig_n   = req.payload.dividend;
    w0_d.want_rem = req.payload.req_type[0];
    w0_d.neg_q    = nn ^ dn;
    w0_d.neg_r    = nn;
    w0_d.dz       = (req.payload.divisor == '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && req.valid) work_q[0] <= w0_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= req.valid;
      for (int s = 0; s < NStage; s++) begin
        if (adv[s+1]) vld_q[s+1] <= vld_q[s];
      end
    end
  end

  // restoring stages; quo shifts out dividend bits and in quotient bits
  for (genvar s = 0; s < NStage; s++) begin : g_stage
    dm_work_t w_d;
    logic [DataW:0] trial;
    always_comb begin
      w_d = work_q[s];
      trial = '0;
      for (int b = 0; b < BitsPerStage; b++) begin
        trial = {w_d.rem, w_d.quo[DataW-1]} - {1'b0, w_d.den};
        if (!trial[DataW]) begin
          w_d.rem = trial[DataW-1:0];
          w_d.quo = {w_d.quo[DataW-2:0], 1'b1};
        end else begin
          w_d.rem = {w_d.rem[DataW-2:0], w_d.quo[DataW-1]};
          w_d.quo = {w_d.quo[DataW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv[s+1] && vld_q[s]) work_q[s+1] <= w_d;
    end
  end

  // output stage: sign fix and zero-divisor convention
  dm_rsp_t  o_d;
  dm_work_t wl;
  always_comb begin
    wl = work_q[NStage];
    o_d.divide_by_zero = wl.dz;
    if (wl.dz) begin
      o_d.answer = wl.want_rem ? wl.orig_n : '1;
    end else if (wl.want_rem) begin
      o_d.answer = wl.neg_r ? (DataW'(0) - wl.rem) : wl.rem;
    end else begin
      o_d.answer = wl.neg_q ? (DataW'(0) - wl.quo) : wl.quo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && vld_q[NStage]) out_q <= o_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= vld_q[NStage];
    end
  end

  assign rsp.valid   = out_vld_q;
  assign rsp.payload = out_q;
endmodule

// ===== hw/rtl/i64dm_checker.sv =====
// port-level assertions for the divider, bound to the top level
`timescale 1ns / 1ps
`include "int64_divide_modulo_defines.svh"
module i64dm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input i64dm_pkg::dm_rsp_t rsp_payload
);
  import i64dm_pkg::*;

  `DM_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
  `DM_ASSERT_IMPL(a_ready_free, clk_i, rst_ni, !rsp_valid, req_ready)
  `DM_ASSERT_IMPL(a_rsp_known, clk_i, rst_ni, rsp_valid, !$isunknown(rsp_payload))
endmodule

bind int64_divide_modulo i64dm_checker u_i64dm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);
